FILE: rtl/swarq_pkg.sv
package swarq_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_RX   = 2'd0;
    localparam logic [1:0] FUNC_SEND = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Frame type codes, header bits 31:30
    localparam logic [1:0] FT_DATA = 2'd0;
    localparam logic [1:0] FT_TEST = 2'd1;
    localparam logic [1:0] FT_REJ  = 2'd2;
    localparam logic [1:0] FT_ACK  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CTL   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DELIV = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_RTO         = 2'd1;
    localparam logic [1:0] REG_PING_TMO    = 2'd2;
    localparam logic [1:0] REG_PING_PERIOD = 2'd3;

    localparam int unsigned SEQ_W = 15;
    localparam logic [15:0] CTL_LENGTH = 16'd4;
    localparam logic [16:0] HDR_BYTES  = 17'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] header_word;
        logic [31:0] type_word;
        logic [15:0] buffer_handle;
        logic [15:0] byte_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] out_header;
        logic [31:0] out_type;
        logic [15:0] out_handle;
        logic [15:0] out_length;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  window_size;
        logic [15:0] retransmit_timeout_ms;
        logic [15:0] ping_timeout_ms;
        logic [15:0] ping_period_ms;
    } t_cfg;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [31:0]      ptype;
        logic [15:0]      handle;
        logic [15:0]      length;
        logic [31:0]      sent_at;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_RX_DISP,
        ST_RX_CTL,
        ST_RX_DELIV,
        ST_RS_INIT,
        ST_RS_RD,
        ST_RS_EM,
        ST_TK_CHK,
        ST_TK_PING,
        ST_SND_EM
    } t_state;

    typedef enum logic [1:0] {
        WS_START,
        WS_NEXT,
        WS_RESEND
    } t_wsel;

endpackage

FILE: rtl/sliding_window_arq_link_top.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_in_data  (swarq_pkg::t_in_item)
// out       output     o_out_valid/i_out_stall o_out_data (swarq_pkg::t_out_item)
// cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
// One transaction at a time; the input stalls until the sequencer is back in idle.
// A send stores its descriptor, emits the frame and walks the next index; a received
// frame that acknowledges frames first walks the oldest index before it is handled.
// A resend reduces the oldest index, then reads and emits each entry from the descriptor
// memory; index walks first reduce the index when the window size has shrunk.
// Reset is synchronous, active low; descriptor memory needs no clearing.
// A stalled output register holds the sequencer at its current result.
module sliding_window_arq_link_top #(
    parameter int WINDOW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  swarq_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output swarq_pkg::t_out_item  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    swarq_pkg::t_cfg      r_cfg;
    logic                 r_out_valid;
    swarq_pkg::t_out_item r_out_data;
    logic                 busy, emit_valid, emit_ready;
    swarq_pkg::t_out_item emit_data;
    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_waddr, mem_raddr;
    swarq_pkg::t_entry    mem_wdata, mem_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size           <= 4'd1;
            r_cfg.retransmit_timeout_ms <= 16'd1000;
            r_cfg.ping_timeout_ms       <= 16'd5000;
            r_cfg.ping_period_ms        <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swarq_pkg::REG_WINDOW_SIZE: r_cfg.window_size <= i_cfg_data[3:0];
                swarq_pkg::REG_RTO:         r_cfg.retransmit_timeout_ms <= i_cfg_data;
                swarq_pkg::REG_PING_TMO:    r_cfg.ping_timeout_ms <= i_cfg_data;
                swarq_pkg::REG_PING_PERIOD: r_cfg.ping_period_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register: load when empty or draining
    assign emit_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid && emit_ready) begin
            r_out_data <= emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_in_stall  = busy;

    swarq_ctrl #(.WINDOW(WINDOW)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_busy       (busy),
        .o_emit_valid (emit_valid),
        .o_emit_data  (emit_data),
        .i_emit_ready (emit_ready),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    swarq_mem #(.WINDOW(WINDOW)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

endmodule

FILE: rtl/swarq_mem.sv
module swarq_mem #(
    parameter int WINDOW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] i_wr_addr,
    input  swarq_pkg::t_entry      i_wr_data,
    input  logic                   i_rd_en,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] i_rd_addr,
    output swarq_pkg::t_entry      o_rd_data
);

    swarq_pkg::t_entry r_mem [WINDOW];
    swarq_pkg::t_entry r_rd_data;

    // Write descriptor
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/swarq_ctrl.sv
module swarq_ctrl #(
    parameter int WINDOW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swarq_pkg::t_cfg        i_cfg,
    input  logic                   i_in_valid,
    input  swarq_pkg::t_in_item    i_in_data,
    output logic                   o_busy,
    output logic                   o_emit_valid,
    output swarq_pkg::t_out_item   o_emit_data,
    input  logic                   i_emit_ready,
    output logic                   o_mem_we,
    output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] o_mem_waddr,
    output swarq_pkg::t_entry      o_mem_wdata,
    output logic                   o_mem_re,
    output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] o_mem_raddr,
    input  swarq_pkg::t_entry      i_mem_rdata
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = $clog2(WINDOW + 1);
    localparam int QW = swarq_pkg::SEQ_W;

    swarq_pkg::t_state r_state, n_state, r_after, n_after;
    swarq_pkg::t_wsel  r_wsel, n_wsel;
    logic [SW-1:0] r_w, n_w, r_wcnt, n_wcnt;
    logic [IW-1:0] r_start_idx, n_start_idx, r_next_idx, n_next_idx;
    logic [QW-1:0] r_start_seq, n_start_seq, r_next_seq, n_next_seq;
    logic [QW-1:0] r_exp, n_exp;
    logic [SW-1:0] r_fif, n_fif, r_ridx, n_ridx, r_rcnt, n_rcnt;
    logic [15:0]   r_pings, n_pings;
    logic [31:0]   r_ms, n_ms, r_now, n_now;
    logic          r_ping, n_ping, r_deliv, n_deliv;
    logic [1:0]    r_ctl, n_ctl;
    logic [31:0]   r_hdr, n_hdr, r_type, n_type, r_prod, n_prod;
    logic [15:0]   r_handle, n_handle, r_blen, n_blen;

    logic [5:0]    ws_ext, eff;
    logic [SW-1:0] sz;
    logic [QW-1:0] ack_d;
    logic          ack_hit;
    logic signed [33:0] quiet;
    logic          ping_due, rto_due;
    logic [16:0]   rs_len, snd_len;
    logic [SW-1:0] ridx_inc;

    // Effective window size, clamped to 1..WINDOW
    assign ws_ext = {2'b00, i_cfg.window_size};
    assign eff = (ws_ext == 6'd0) ? 6'd1 :
                 (ws_ext > 6'(WINDOW)) ? 6'(WINDOW) : ws_ext;
    assign sz = SW'(eff);

    // Acknowledge distance from the incoming receive sequence
    assign ack_d = i_in_data.header_word[QW-1:0] - QW'(1) - r_start_seq;
    assign ack_hit = ack_d < QW'(r_fif);

    // Keepalive and retransmit decisions
    assign quiet = $signed({2'b00, r_ms}) - $signed({2'b00, r_prod});
    assign ping_due = quiet >= $signed({18'd0, i_cfg.ping_timeout_ms});
    assign rto_due = (r_now - i_mem_rdata.sent_at) >= {16'd0, i_cfg.retransmit_timeout_ms};

    assign rs_len = {1'b0, i_mem_rdata.length} + swarq_pkg::HDR_BYTES;
    assign snd_len = {1'b0, r_blen} + swarq_pkg::HDR_BYTES;
    assign ridx_inc = ((r_ridx + SW'(1)) == sz) ? '0 : r_ridx + SW'(1);

    assign o_busy = (r_state != swarq_pkg::ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swarq_pkg::ST_IDLE;
            r_start_idx <= '0;
            r_start_seq <= '0;
            r_next_idx  <= '0;
            r_next_seq  <= '0;
            r_fif       <= '0;
            r_exp       <= '0;
            r_pings     <= '0;
            r_ms        <= '0;
            r_now       <= '0;
        end else begin
            r_state     <= n_state;
            r_start_idx <= n_start_idx;
            r_start_seq <= n_start_seq;
            r_next_idx  <= n_next_idx;
            r_next_seq  <= n_next_seq;
            r_fif       <= n_fif;
            r_exp       <= n_exp;
            r_pings     <= n_pings;
            r_ms        <= n_ms;
            r_now       <= n_now;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_after  <= n_after;
        r_wsel   <= n_wsel;
        r_w      <= n_w;
        r_wcnt   <= n_wcnt;
        r_ridx   <= n_ridx;
        r_rcnt   <= n_rcnt;
        r_ping   <= n_ping;
        r_deliv  <= n_deliv;
        r_ctl    <= n_ctl;
        r_hdr    <= n_hdr;
        r_type   <= n_type;
        r_prod   <= n_prod;
        r_handle <= n_handle;
        r_blen   <= n_blen;
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;       n_after = r_after;     n_wsel = r_wsel;
        n_w = r_w;               n_wcnt = r_wcnt;
        n_start_idx = r_start_idx; n_start_seq = r_start_seq;
        n_next_idx = r_next_idx; n_next_seq = r_next_seq;
        n_fif = r_fif;           n_exp = r_exp;         n_pings = r_pings;
        n_ms = r_ms;             n_now = r_now;
        n_ridx = r_ridx;         n_rcnt = r_rcnt;
        n_ping = r_ping;         n_deliv = r_deliv;     n_ctl = r_ctl;
        n_hdr = r_hdr;           n_type = r_type;       n_prod = r_prod;
        n_handle = r_handle;     n_blen = r_blen;
        o_emit_valid = 1'b0;
        o_emit_data  = '0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_next_idx;
        o_mem_wdata  = i_mem_rdata;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_start_idx;

        unique case (r_state)
            swarq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_hdr    = i_in_data.header_word;
                    n_type   = i_in_data.type_word;
                    n_handle = i_in_data.buffer_handle;
                    n_blen   = i_in_data.byte_length;
                    case (i_in_data.func)
                        swarq_pkg::FUNC_RX: begin
                            n_ms    = '0;
                            n_pings = '0;
                            if (ack_hit) begin
                                n_start_seq = i_in_data.header_word[QW-1:0];
                                n_fif   = r_fif - (SW'(ack_d) + SW'(1));
                                n_w     = SW'(r_start_idx);
                                n_wcnt  = SW'(ack_d) + SW'(1);
                                n_wsel  = swarq_pkg::WS_START;
                                n_after = swarq_pkg::ST_RX_DISP;
                                n_state = swarq_pkg::ST_WALK;
                            end else begin
                                n_state = swarq_pkg::ST_RX_DISP;
                            end
                        end
                        swarq_pkg::FUNC_SEND: begin
                            // Store descriptor unless window is full
                            if (r_fif < sz) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_next_idx;
                                o_mem_wdata = '{seq: r_next_seq,
                                                ptype: i_in_data.type_word,
                                                handle: i_in_data.buffer_handle,
                                                length: i_in_data.byte_length,
                                                sent_at: r_now};
                                n_state = swarq_pkg::ST_SND_EM;
                            end
                        end
                        swarq_pkg::FUNC_TICK: begin
                            n_now = r_now + 32'd1;
                            if (r_ms != '1) begin
                                n_ms = r_ms + 32'd1;
                            end
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_start_idx;
                            n_prod  = {16'd0, r_pings} * {16'd0, i_cfg.ping_period_ms};
                            n_state = swarq_pkg::ST_TK_CHK;
                        end
                        default: ;
                    endcase
                end
            end

            // Step an index modulo the window size, one add or subtract per cycle
            swarq_pkg::ST_WALK: begin
                if (r_w >= sz) begin
                    n_w = r_w - sz;
                end else if (r_wcnt != '0) begin
                    n_w    = r_w + SW'(1);
                    n_wcnt = r_wcnt - SW'(1);
                end else begin
                    unique case (r_wsel)
                        swarq_pkg::WS_START: n_start_idx = IW'(r_w);
                        swarq_pkg::WS_NEXT:  n_next_idx  = IW'(r_w);
                        swarq_pkg::WS_RESEND: begin
                            n_ridx = r_w;
                            n_rcnt = r_fif;
                        end
                        default: ;
                    endcase
                    n_state = r_after;
                end
            end

            swarq_pkg::ST_RX_DISP: begin
                unique case (r_hdr[31:30])
                    swarq_pkg::FT_DATA: begin
                        if (r_hdr[2*QW-1:QW] == r_exp) begin
                            n_exp   = r_exp + QW'(1);
                            n_ctl   = swarq_pkg::FT_ACK;
                            n_deliv = 1'b1;
                        end else begin
                            n_ctl   = swarq_pkg::FT_REJ;
                            n_deliv = 1'b0;
                        end
                        n_state = swarq_pkg::ST_RX_CTL;
                    end
                    swarq_pkg::FT_TEST: begin
                        n_ctl   = swarq_pkg::FT_ACK;
                        n_deliv = 1'b0;
                        n_state = swarq_pkg::ST_RX_CTL;
                    end
                    swarq_pkg::FT_REJ: begin
                        n_ping  = 1'b0;
                        n_state = swarq_pkg::ST_RS_INIT;
                    end
                    default: n_state = swarq_pkg::ST_IDLE;
                endcase
            end

            swarq_pkg::ST_RX_CTL: begin
                o_emit_valid = 1'b1;
                o_emit_data  = '{out_kind: swarq_pkg::KIND_CTL,
                                 out_header: {r_ctl, 15'd0, r_exp},
                                 out_type: 32'd0, out_handle: 16'd0,
                                 out_length: swarq_pkg::CTL_LENGTH,
                                 last_of_run: !r_deliv};
                if (i_emit_ready) begin
                    n_state = r_deliv ? swarq_pkg::ST_RX_DELIV : swarq_pkg::ST_IDLE;
                end
            end

            swarq_pkg::ST_RX_DELIV: begin
                o_emit_valid = 1'b1;
                o_emit_data  = '{out_kind: swarq_pkg::KIND_DELIV,
                                 out_header: r_hdr, out_type: r_type,
                                 out_handle: r_handle,
                                 out_length: (r_blen >= 16'd8) ? r_blen - 16'd8 : 16'd0,
                                 last_of_run: 1'b1};
                if (i_emit_ready) begin
                    n_state = swarq_pkg::ST_IDLE;
                end
            end

            // Reduce the oldest index, then resend the window
            swarq_pkg::ST_RS_INIT: begin
                if (r_fif == '0) begin
                    n_state = r_ping ? swarq_pkg::ST_TK_PING : swarq_pkg::ST_IDLE;
                end else begin
                    n_w     = SW'(r_start_idx);
                    n_wcnt  = '0;
                    n_wsel  = swarq_pkg::WS_RESEND;
                    n_after = swarq_pkg::ST_RS_RD;
                    n_state = swarq_pkg::ST_WALK;
                end
            end

            swarq_pkg::ST_RS_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = IW'(r_ridx);
                n_state     = swarq_pkg::ST_RS_EM;
            end

            swarq_pkg::ST_RS_EM: begin
                o_emit_valid = 1'b1;
                o_emit_data  = '{out_kind: swarq_pkg::KIND_DATA,
                                 out_header: {2'b00, i_mem_rdata.seq, r_exp},
                                 out_type: i_mem_rdata.ptype,
                                 out_handle: i_mem_rdata.handle,
                                 out_length: rs_len[16] ? 16'hffff : rs_len[15:0],
                                 last_of_run: (r_rcnt == SW'(1)) && !r_ping};
                if (i_emit_ready) begin
                    // Restamp the resent entry
                    o_mem_we    = 1'b1;
                    o_mem_waddr = IW'(r_ridx);
                    o_mem_wdata = i_mem_rdata;
                    o_mem_wdata.sent_at = r_now;
                    n_ridx = ridx_inc;
                    n_rcnt = r_rcnt - SW'(1);
                    if (r_rcnt == SW'(1)) begin
                        n_state = r_ping ? swarq_pkg::ST_TK_PING : swarq_pkg::ST_IDLE;
                    end else begin
                        n_state = swarq_pkg::ST_RS_RD;
                    end
                end
            end

            swarq_pkg::ST_TK_CHK: begin
                n_ping = ping_due;
                if ((r_fif != '0) && rto_due) begin
                    n_state = swarq_pkg::ST_RS_INIT;
                end else if (ping_due) begin
                    n_state = swarq_pkg::ST_TK_PING;
                end else begin
                    n_state = swarq_pkg::ST_IDLE;
                end
            end

            swarq_pkg::ST_TK_PING: begin
                o_emit_valid = 1'b1;
                o_emit_data  = '{out_kind: swarq_pkg::KIND_CTL,
                                 out_header: {swarq_pkg::FT_TEST, 15'd0, r_exp},
                                 out_type: 32'd0, out_handle: 16'd0,
                                 out_length: swarq_pkg::CTL_LENGTH,
                                 last_of_run: 1'b1};
                if (i_emit_ready) begin
                    if (r_pings != '1) begin
                        n_pings = r_pings + 16'd1;
                    end
                    n_state = swarq_pkg::ST_IDLE;
                end
            end

            swarq_pkg::ST_SND_EM: begin
                o_emit_valid = 1'b1;
                o_emit_data  = '{out_kind: swarq_pkg::KIND_DATA,
                                 out_header: {2'b00, r_next_seq, r_exp},
                                 out_type: r_type, out_handle: r_handle,
                                 out_length: snd_len[16] ? 16'hffff : snd_len[15:0],
                                 last_of_run: 1'b1};
                if (i_emit_ready) begin
                    n_next_seq = r_next_seq + QW'(1);
                    n_fif   = r_fif + SW'(1);
                    n_w     = SW'(r_next_idx);
                    n_wcnt  = SW'(1);
                    n_wsel  = swarq_pkg::WS_NEXT;
                    n_after = swarq_pkg::ST_IDLE;
                    n_state = swarq_pkg::ST_WALK;
                end
            end

            default: n_state = swarq_pkg::ST_IDLE;
        endcase
    end

endmodule
